/* sv/fbpa_pkg.sv */
// fbpa_pkg: types and constants of the fixed-size block pool allocator
// no dependencies; imported by fixed_block_pool_allocator

package fbpa_pkg;

  localparam int ADDR_W    = 32;
  localparam int SIZE_W    = 16;
  localparam int CNT_W     = 11;
  localparam int ROW_W     = 32;  // used flags per memory word
  localparam int BIT_W     = 5;   // log2 of ROW_W
  localparam int SPAN_W    = SIZE_W + CNT_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [ADDR_W-1:0] HDR_BYTES  = 32'd4;
  localparam logic [SIZE_W-1:0] MIN_BLOCK  = 16'd5;
  localparam logic              USED_MARK  = 1'b1;

  localparam logic [ADDR_W-1:0] RST_POOL_BASE   = 32'd0;
  localparam logic [SIZE_W-1:0] RST_BLOCK_SIZE  = 16'd8;
  localparam logic [CNT_W-1:0]  RST_BLOCK_COUNT = 11'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE   = 2'd0,
    CFG_BLOCK_SIZE  = 2'd1,
    CFG_BLOCK_COUNT = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BADADDR = 2'd2,
    ST_DOUBLE  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_A_RD,
    S_A_MOD,
    S_A_OUT,
    S_F_CHK,
    S_F_DIV,
    S_F_TST,
    S_F_MOD
  } state_t;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] user_addr;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] block_addr;
    logic [CNT_W-1:0]  free_blocks;
    logic [CNT_W-1:0]  used_blocks;
  } rsp_t;

endpackage

/* sv/fixed_block_pool_allocator.sv */
// fixed_block_pool_allocator: one pool of equal blocks with a 4-byte header each
// depends on fbpa_pkg

// Commands are taken when start is high and busy is low; each command gives one
// result beat on rsp, marked by done for one cycle, which the receiver must take.
// The used flags live in one synchronous memory of 32-flag words, with a per-word
// valid bit and a per-word full bit in flops, so reset and register writes take
// effect at once with no clearing pass. An allocate reads the word, modifies and
// writes it back, forms the address and registers the result, or gives an empty
// result straight from idle when no block is free. A free checks the offset against
// the pool, turns it into a block index with the restoring divider, one quotient
// bit per cycle, tests that the remainder is zero and then clears the used flag or
// reports a double free; it ends after the test when the offset is off a block
// boundary, or after the check when it lies outside the pool. busy drops in the
// cycle the result beat is shown, so the next command can be taken at the edge that
// takes the result. A write to any register but CFG_UNUSED re-creates the pool.

module fixed_block_pool_allocator
  import fbpa_pkg::*;
#(
  parameter int MAX_BLOCKS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  req_t                 req,
  output logic                 done,
  output rsp_t                 rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [ADDR_W-1:0]    cfg_data
);

  localparam int ROWS   = (MAX_BLOCKS + ROW_W - 1) / ROW_W;
  localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IW     = RW + BIT_W;
  localparam int DW     = SIZE_W + IW;
  localparam int STEP_W = $clog2(IW + 1);

  // configuration
  logic [ADDR_W-1:0] pool_base;
  logic [SIZE_W-1:0] block_size;
  logic [CNT_W-1:0]  block_count;

  // pool state
  logic [ROW_W-1:0]  flag_mem [ROWS];
  logic [ROWS-1:0]   row_vld;
  logic [ROWS-1:0]   row_full;
  logic              cache_valid;
  logic [IW-1:0]     cache_index;
  logic [CNT_W-1:0]  free_count;
  logic [CNT_W-1:0]  used_count;

  // command datapath
  state_t            state, state_next;
  logic [RW-1:0]     row_r;
  logic [BIT_W-1:0]  bit_r;
  logic              scan_r;
  logic [ADDR_W-1:0] offset_r;
  logic [SPAN_W-1:0] span_r;
  logic [DW-1:0]     rem_r;
  logic [DW-1:0]     dvs_r;
  logic [IW-1:0]     quo_r;
  logic [STEP_W-1:0] step_r;
  logic [ADDR_W-1:0] prod_r;
  logic [ROW_W-1:0]  rd_word;
  logic              rd_ok;
  logic              rsp_done_next;
  rsp_t              rsp_next;

  logic              accept;
  logic              cfg_hit;
  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  cfg_count;
  logic [CNT_W-1:0]  cfg_n;
  logic [SIZE_W-1:0] size_eff;
  logic [RW-1:0]     rd_row;
  logic [RW-1:0]     scan_row;
  logic [ROW_W-1:0]  word_in;
  logic [ADDR_W-1:0] row_lim;
  logic [ROW_W-1:0]  in_mask;
  logic [ROW_W-1:0]  masked;
  logic [BIT_W-1:0]  first_zero;
  logic [BIT_W-1:0]  a_bit;
  logic [ROW_W-1:0]  a_word;
  logic [ROW_W-1:0]  f_word;
  logic              div_ge;
  logic              bad_range;
  logic              mem_we;
  logic [ROW_W-1:0]  wr_word;

  assign busy    = (state != S_IDLE);
  assign accept  = start & ~busy;
  assign cfg_hit = cfg_we && (cfg_addr != CFG_UNUSED);

  assign n_eff    = (32'(block_count) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : block_count;
  assign size_eff = (block_size < MIN_BLOCK) ? MIN_BLOCK : block_size;

  // pool size after a register write re-creates the pool
  assign cfg_count = (cfg_addr == CFG_BLOCK_COUNT) ? cfg_data[CNT_W-1:0] : block_count;
  assign cfg_n     = (32'(cfg_count) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : cfg_count;

  // first word with a free block inside the pool
  always_comb begin
    scan_row = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (!row_full[r] && ((32'(r) << BIT_W) < 32'(n_eff))) begin
        scan_row = RW'(r);
      end
    end
  end

  // flags of a word never written read as free
  assign word_in = rd_ok ? rd_word : '0;
  assign row_lim = 32'(n_eff) - (32'(row_r) << BIT_W);

  always_comb begin
    for (int b = 0; b < ROW_W; b++) begin
      in_mask[b] = (32'(b) < row_lim);
    end
  end

  assign masked = word_in | ~in_mask;

  always_comb begin
    first_zero = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (!masked[b]) begin
        first_zero = BIT_W'(b);
      end
    end
  end

  assign a_bit     = scan_r ? first_zero : bit_r;
  assign a_word    = word_in | (ROW_W'(USED_MARK) << a_bit);
  assign f_word    = word_in & ~(ROW_W'(USED_MARK) << bit_r);
  assign div_ge    = (rem_r >= dvs_r);
  assign bad_range = (offset_r >= 32'(span_r));
  assign rd_row    = (state == S_F_TST) ? quo_r[IW-1:BIT_W] : row_r;

  // flag memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      flag_mem[row_r] <= wr_word;
    end
    rd_word <= flag_mem[rd_row];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= rsp_done_next;
    end
  end

  always_comb begin
    state_next    = state;
    rsp_done_next = 1'b0;
    rsp_next      = rsp;
    mem_we        = 1'b0;
    wr_word       = a_word;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.cmd == CMD_FREE) begin
            state_next = S_F_CHK;
          end else if (free_count == '0) begin
            rsp_done_next        = 1'b1;
            rsp_next.status      = ST_EMPTY;
            rsp_next.block_addr  = '0;
            rsp_next.free_blocks = free_count;
            rsp_next.used_blocks = used_count;
          end else begin
            state_next = S_A_RD;
          end
        end
      end
      S_A_RD: state_next = S_A_MOD;
      S_A_MOD: begin
        mem_we     = 1'b1;
        wr_word    = a_word;
        state_next = S_A_OUT;
      end
      S_A_OUT: begin
        rsp_done_next        = 1'b1;
        rsp_next.status      = ST_OK;
        rsp_next.block_addr  = pool_base + prod_r + HDR_BYTES;
        rsp_next.free_blocks = free_count;
        rsp_next.used_blocks = used_count;
        state_next           = S_IDLE;
      end
      S_F_CHK: begin
        if (bad_range) begin
          rsp_done_next        = 1'b1;
          rsp_next.status      = ST_BADADDR;
          rsp_next.block_addr  = '0;
          rsp_next.free_blocks = free_count;
          rsp_next.used_blocks = used_count;
          state_next           = S_IDLE;
        end else begin
          state_next = S_F_DIV;
        end
      end
      S_F_DIV: begin
        if (step_r == STEP_W'(IW - 1)) begin
          state_next = S_F_TST;
        end
      end
      S_F_TST: begin
        if (rem_r != '0) begin
          rsp_done_next        = 1'b1;
          rsp_next.status      = ST_BADADDR;
          rsp_next.block_addr  = '0;
          rsp_next.free_blocks = free_count;
          rsp_next.used_blocks = used_count;
          state_next           = S_IDLE;
        end else begin
          state_next = S_F_MOD;
        end
      end
      S_F_MOD: begin
        rsp_done_next       = 1'b1;
        rsp_next.block_addr = '0;
        wr_word             = f_word;
        if (word_in[bit_r] == USED_MARK) begin
          mem_we               = 1'b1;
          rsp_next.status      = ST_OK;
          rsp_next.free_blocks = free_count + CNT_W'(1);
          rsp_next.used_blocks = used_count - CNT_W'(1);
        end else begin
          rsp_next.status      = ST_DOUBLE;
          rsp_next.free_blocks = free_count;
          rsp_next.used_blocks = used_count;
        end
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // result register, payload only
  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base   <= RST_POOL_BASE;
      block_size  <= RST_BLOCK_SIZE;
      block_count <= RST_BLOCK_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_POOL_BASE:   pool_base   <= cfg_data;
        CFG_BLOCK_SIZE:  block_size  <= cfg_data[SIZE_W-1:0];
        CFG_BLOCK_COUNT: block_count <= cfg_data[CNT_W-1:0];
        CFG_UNUSED:      ;
        default:         ;
      endcase
    end
  end

  // pool bookkeeping; reset and every cfg_hit register write re-create the pool
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld     <= '0;
      row_full    <= '0;
      cache_index <= '0;
      free_count  <= (32'(RST_BLOCK_COUNT) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                               : RST_BLOCK_COUNT;
      cache_valid <= 1'b1;
      used_count  <= '0;
    end else if (cfg_hit) begin
      row_vld     <= '0;
      row_full    <= '0;
      cache_index <= '0;
      free_count  <= cfg_n;
      cache_valid <= (cfg_n != '0);
      used_count  <= '0;
    end else begin
      if (state == S_IDLE && accept && req.cmd == CMD_ALLOC && free_count != '0) begin
        cache_valid <= 1'b0;
      end
      if (state == S_A_MOD) begin
        row_vld[row_r]  <= 1'b1;
        row_full[row_r] <= &(a_word | ~in_mask);
        free_count      <= free_count - CNT_W'(1);
        used_count      <= used_count + CNT_W'(1);
      end
      if (state == S_F_MOD && word_in[bit_r] == USED_MARK) begin
        row_vld[row_r]  <= 1'b1;
        row_full[row_r] <= 1'b0;
        free_count      <= free_count + CNT_W'(1);
        used_count      <= used_count - CNT_W'(1);
        if (!cache_valid) begin
          cache_valid <= 1'b1;
          cache_index <= {row_r, bit_r};
        end
      end
    end
  end

  // command datapath
  always_ff @(posedge clk) begin
    span_r <= SPAN_W'(size_eff) * SPAN_W'(n_eff);
    rd_ok  <= row_vld[rd_row];
    unique case (state)
      S_IDLE: begin
        offset_r <= req.user_addr - HDR_BYTES - pool_base;
        if (cache_valid) begin
          row_r  <= cache_index[IW-1:BIT_W];
          bit_r  <= cache_index[BIT_W-1:0];
          scan_r <= 1'b0;
        end else begin
          row_r  <= scan_row;
          scan_r <= 1'b1;
        end
      end
      S_A_MOD: begin
        prod_r <= 32'(size_eff) * 32'({row_r, a_bit});
      end
      S_F_CHK: begin
        rem_r  <= offset_r[DW-1:0];
        dvs_r  <= DW'(size_eff) << (IW - 1);
        quo_r  <= '0;
        step_r <= '0;
      end
      S_F_DIV: begin
        // restoring division, one quotient bit a cycle
        if (div_ge) begin
          rem_r <= rem_r - dvs_r;
        end
        quo_r  <= {quo_r[IW-2:0], div_ge};
        dvs_r  <= dvs_r >> 1;
        step_r <= step_r + STEP_W'(1);
      end
      S_F_TST: begin
        row_r <= quo_r[IW-1:BIT_W];
        bit_r <= quo_r[BIT_W-1:0];
      end
      S_A_RD, S_A_OUT, S_F_MOD: ;
      default: ;
    endcase
  end

endmodule

/* sim/fixed_block_pool_allocator_tb.sv */
// fixed_block_pool_allocator_tb: self-checking bench for the block pool allocator
// directed table then random alloc/free bursts over several pool setups, each result
// checked against its table entry or the bench's pool model; depends on fbpa_pkg, dut

module fixed_block_pool_allocator_tb;
  import fbpa_pkg::*;

  localparam int POOL_MAX = 1024;
  localparam int SETTLE   = 4;

  typedef struct packed {
    bit       is_cfg;
    cfg_idx_t sel;
    logic [ADDR_W-1:0] val;
    cmd_t     cmd;
    bit       typed;
    rsp_t     want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  req_t                 req;
  logic                 done;
  rsp_t                 rsp;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [ADDR_W-1:0]    cfg_data;

  // pool as the block should hold it
  logic [ADDR_W-1:0] cfg_base;
  logic [SIZE_W-1:0] cfg_size;
  logic [CNT_W-1:0]  cfg_count;
  bit                blk_used [POOL_MAX];
  bit                cache_ok;
  int unsigned       cache_blk;
  int unsigned       n_free;
  int unsigned       n_used;

  rsp_t      rsp_due [$];
  stim_row_t dir_rows [$];
  int        errors = 0;
  int        shown = 0;
  int        idle_pct = 0;

  fixed_block_pool_allocator #(
    .MAX_BLOCKS(POOL_MAX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned pool_blocks();
    return (cfg_count > POOL_MAX) ? POOL_MAX : cfg_count;
  endfunction

  function automatic int unsigned block_bytes();
    return (cfg_size < MIN_BLOCK) ? MIN_BLOCK : cfg_size;
  endfunction

  function automatic logic [ADDR_W-1:0] user_addr_at(int unsigned idx);
    logic [ADDR_W-1:0] step;
    step = idx * block_bytes();
    return cfg_base + step + HDR_BYTES;
  endfunction

  function automatic void pool_clear();
    foreach (blk_used[i]) blk_used[i] = 1'b0;
    n_free    = pool_blocks();
    n_used    = 0;
    cache_ok  = (n_free > 0);
    cache_blk = 0;
  endfunction

  function automatic void apply_cfg(cfg_idx_t sel, logic [ADDR_W-1:0] d);
    case (sel)
      CFG_POOL_BASE:   cfg_base = d;
      CFG_BLOCK_SIZE:  cfg_size = d[SIZE_W-1:0];
      CFG_BLOCK_COUNT: cfg_count = d[CNT_W-1:0];
      default: ;
    endcase
    // any real register write rebuilds the pool
    if (sel != CFG_UNUSED) pool_clear();
  endfunction

  function automatic rsp_t predict_pool_op(req_t r);
    rsp_t              o;
    int unsigned       n;
    int unsigned       sz;
    int unsigned       idx;
    int unsigned       i;
    bit                hit;
    logic [ADDR_W-1:0] off;
    logic [63:0]       span;
    n   = pool_blocks();
    sz  = block_bytes();
    o   = '0;
    hit = 1'b0;
    idx = 0;
    o.status = ST_OK;
    if (r.cmd == CMD_ALLOC) begin
      if (n_free == 0) begin
        o.status = ST_EMPTY;
      end else if (cache_ok && cache_blk < n) begin
        idx      = cache_blk;
        hit      = 1'b1;
        cache_ok = 1'b0;
      end else begin
        for (i = 0; i < n && !hit; i++) begin
          if (!blk_used[i]) begin
            idx = i;
            hit = 1'b1;
          end
        end
        if (!hit) o.status = ST_EMPTY;
      end
      if (hit) begin
        blk_used[idx] = USED_MARK;
        if (n_free > 0) n_free--;
        n_used++;
        o.block_addr = user_addr_at(idx);
      end
    end else begin
      off  = r.user_addr - HDR_BYTES - cfg_base;
      span = 64'(sz) * 64'(n);
      if (64'(off) >= span || (off % sz) != 0) begin
        o.status = ST_BADADDR;
      end else begin
        idx = off / sz;
        if (idx >= POOL_MAX || !blk_used[idx]) begin
          o.status = ST_DOUBLE;
        end else begin
          blk_used[idx] = 1'b0;
          if (!cache_ok) begin
            cache_ok  = 1'b1;
            cache_blk = idx;
          end
          n_free++;
          if (n_used > 0) n_used--;
        end
      end
    end
    o.free_blocks = n_free[CNT_W-1:0];
    o.used_blocks = n_used[CNT_W-1:0];
    return o;
  endfunction

  // mostly live blocks, then stale, misaligned and out-of-pool pointers
  function automatic logic [ADDR_W-1:0] pick_free_addr();
    int unsigned n;
    int unsigned sz;
    int unsigned s;
    int unsigned k;
    int          idx;
    int          roll;
    n    = pool_blocks();
    sz   = block_bytes();
    roll = $urandom_range(99);
    idx  = -1;
    if (n == 0 || roll >= 92) return $urandom();
    if (roll < 55) begin
      s = $urandom_range(n - 1);
      for (k = 0; k < n && idx < 0; k++) begin
        if (blk_used[(s + k) % n]) idx = (s + k) % n;
      end
    end
    if (idx < 0) idx = $urandom_range(n - 1);
    if (roll < 70) return user_addr_at(idx);
    if (roll < 82) return user_addr_at(idx) + $urandom_range(sz - 1, 1);
    if (roll[0]) return user_addr_at(n + $urandom_range(3));
    return user_addr_at(0) - sz * $urandom_range(3, 1);
  endfunction

  task automatic put_cfg(cfg_idx_t sel, logic [ADDR_W-1:0] v);
    stim_row_t row;
    row        = '0;
    row.is_cfg = 1'b1;
    row.sel    = sel;
    row.val    = v;
    dir_rows.push_back(row);
  endtask

  task automatic put_op(cmd_t c, logic [ADDR_W-1:0] a, bit typed, status_t st,
                        logic [ADDR_W-1:0] ba, int fr, int us);
    stim_row_t row;
    row                  = '0;
    row.cmd              = c;
    row.val              = a;
    row.typed            = typed;
    row.want.status      = st;
    row.want.block_addr  = ba;
    row.want.free_blocks = fr[CNT_W-1:0];
    row.want.used_blocks = us[CNT_W-1:0];
    dir_rows.push_back(row);
  endtask

  // start stays high from one accepted beat to the next unless a gap is drawn
  task automatic send_item(req_t r, bit typed, rsp_t want);
    int   gap;
    rsp_t calc;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 12) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    calc = predict_pool_op(r);
    rsp_due.push_back(typed ? want : calc);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t sel, logic [ADDR_W-1:0] d);
    cfg_we   <= 1'b1;
    cfg_addr <= sel;
    cfg_data <= d;
    @(posedge clk);
    apply_cfg(sel, d);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin : check_beats
    rsp_t want;
    if (!rst && done) begin
      if (rsp_due.size() == 0) begin
        errors++;
        if (shown < 10) $display("unexpected result beat: %p", rsp);
        shown++;
      end else begin
        want = rsp_due.pop_front();
        if (rsp.status !== want.status || rsp.block_addr !== want.block_addr ||
            rsp.free_blocks !== want.free_blocks ||
            rsp.used_blocks !== want.used_blocks) begin
          errors++;
          if (shown < 10)
            $display("mismatch (exp/got): status %0d/%0d addr %h/%h free %0d/%0d used %0d/%0d",
                     want.status, rsp.status, want.block_addr, rsp.block_addr,
                     want.free_blocks, rsp.free_blocks, want.used_blocks, rsp.used_blocks);
          shown++;
        end
      end
    end
  end

  initial begin
    #1600000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    req_t              r;
    rsp_t              none;
    cfg_idx_t          sel;
    logic [ADDR_W-1:0] base_v;
    logic [ADDR_W-1:0] d;
    int unsigned       size_v;
    int unsigned       count_v;
    int                seg;
    int                i;
    int                j;
    int                first;
    int                w;

    rst      = 1'b1;
    start    = 1'b0;
    req      = '0;
    cfg_we   = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    none     = '0;

    cfg_base  = RST_POOL_BASE;
    cfg_size  = RST_BLOCK_SIZE;
    cfg_count = RST_BLOCK_COUNT;
    pool_clear();

    // reset pool: base 0, 8-byte blocks, 1024 of them, block 0 cached
    put_op(CMD_ALLOC, 32'h0,          1, ST_OK,      32'd4,  1023, 1);
    put_op(CMD_ALLOC, 32'hFFFF_FFFF,  1, ST_OK,      32'd12, 1022, 2);
    put_op(CMD_FREE,  32'd4,          1, ST_OK,      32'd0,  1023, 1);
    put_op(CMD_FREE,  32'd4,          1, ST_DOUBLE,  32'd0,  1023, 1);
    put_op(CMD_FREE,  32'd5,          1, ST_BADADDR, 32'd0,  1023, 1);
    put_op(CMD_FREE,  32'd0,          1, ST_BADADDR, 32'd0,  1023, 1);
    put_op(CMD_FREE,  32'd8196,       1, ST_BADADDR, 32'd0,  1023, 1);
    put_op(CMD_FREE,  32'hFFFF_FFFF,  1, ST_BADADDR, 32'd0,  1023, 1);
    put_op(CMD_FREE,  32'd8188,       1, ST_DOUBLE,  32'd0,  1023, 1);
    put_op(CMD_ALLOC, 32'h0,          1, ST_OK,      32'd4,  1022, 2);
    // two undersized blocks whose addresses wrap past the top of memory
    put_cfg(CFG_POOL_BASE,   32'hFFFF_FFF8);
    put_cfg(CFG_BLOCK_SIZE,  32'd3);
    put_cfg(CFG_BLOCK_COUNT, 32'd2);
    put_op(CMD_ALLOC, 32'h0,          1, ST_OK,      32'hFFFF_FFFC, 1, 1);
    put_op(CMD_ALLOC, 32'h0,          1, ST_OK,      32'h0000_0001, 0, 2);
    put_op(CMD_ALLOC, 32'h0,          1, ST_EMPTY,   32'd0,  0, 2);
    put_op(CMD_FREE,  32'h0000_0001,  1, ST_OK,      32'd0,  1, 1);
    put_op(CMD_FREE,  32'h0000_0006,  1, ST_BADADDR, 32'd0,  1, 1);
    // empty pool
    put_cfg(CFG_BLOCK_COUNT, 32'd0);
    put_op(CMD_ALLOC, 32'h0,          1, ST_EMPTY,   32'd0,  0, 0);
    put_op(CMD_FREE,  32'hFFFF_FFFC,  1, ST_BADADDR, 32'd0,  0, 0);
    // count beyond the pool size is clipped to 1024
    put_cfg(CFG_BLOCK_COUNT, 32'd2047);
    put_op(CMD_ALLOC, 32'h0,          1, ST_OK,      32'hFFFF_FFFC, 1023, 1);
    put_cfg(CFG_UNUSED,      32'h0001_2345);
    put_op(CMD_ALLOC, 32'h0,          0, ST_OK,      32'd0,  0, 0);
    put_op(CMD_FREE,  32'h0000_0001,  0, ST_OK,      32'd0,  0, 0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) begin
        drain();
        cfg_write(dir_rows[k].sel, dir_rows[k].val);
      end else begin
        r.cmd       = dir_rows[k].cmd;
        r.user_addr = dir_rows[k].val;
        send_item(r, dir_rows[k].typed, dir_rows[k].want);
      end
    end

    for (seg = 0; seg < 8; seg++) begin
      drain();
      case (seg % 4)
        0: idle_pct = 0;
        1: idle_pct = 46;
        2: idle_pct = 0;
        default: idle_pct = 24;
      endcase
      case (seg % 4)
        0: size_v = 65535;
        1: size_v = $urandom_range(4, 0);
        default: size_v = $urandom_range(40, 5);
      endcase
      if (seg == 3) count_v = $urandom_range(2047, 1025);
      else if (seg == 6) count_v = 1024;
      else count_v = $urandom_range(24, 1);
      if (seg == 5) base_v = 32'h0;
      else if (seg == 7) base_v = 32'hFFFF_FFFF;
      else base_v = $urandom();
      first = $urandom_range(2);
      for (j = 0; j < 3; j++) begin
        sel = cfg_idx_t'((first + j) % 3);
        case (sel)
          CFG_POOL_BASE:  d = base_v;
          CFG_BLOCK_SIZE: d = ($urandom() << SIZE_W) | size_v;
          default:        d = ($urandom() << CNT_W) | count_v;
        endcase
        cfg_write(sel, d);
      end
      // alternate fill-heavy and drain-heavy bursts so small pools run full and empty
      for (i = 0; i < 68; i++) begin
        if ($urandom_range(39) == 0) drain();
        r.cmd = ($urandom_range(99) < (((i / 12) % 2 == 0) ? 75 : 25)) ? CMD_ALLOC : CMD_FREE;
        r.user_addr = (r.cmd == CMD_FREE) ? pick_free_addr() : $urandom();
        send_item(r, 1'b0, none);
      end
    end

    start <= 1'b0;
    w = 0;
    while (rsp_due.size() != 0 && w < 5000) begin
      @(posedge clk);
      w++;
    end
    repeat (30) @(posedge clk);
    if (rsp_due.size() != 0) begin
      $display("%0d results never arrived", rsp_due.size());
      errors += rsp_due.size();
    end
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
